>>> rtl/ffa_pkg.sv
package ffa_pkg;

  localparam int unsigned DefaultMaxObjects = 16;
  localparam logic [20:0] SegResetBytes = 21'(4096 * 200);
  localparam logic [20:0] StartMax = 21'h0FFFFF;

  localparam logic [1:0] OpAlloc   = 2'd0;
  localparam logic [1:0] OpFree    = 2'd1;
  localparam logic [1:0] OpAcquire = 2'd2;
  localparam logic [1:0] OpRelease = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StBusy    = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] object_id;
    logic [20:0] request_bytes;
    logic [15:0] attribute;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_id;
    logic [19:0] start_offset;
    logic [20:0] object_bytes;
    logic [15:0] object_attribute;
  } rsp_t;

  typedef struct packed {
    logic [19:0] start;
    logic [20:0] bytes;
    logic [15:0] ident;
    logic [15:0] attr;
    logic        locked;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture request, clear scan state
    logic scan;      // examine entry at index and advance
    logic decide;    // compute allocate result from scan state
    logic shift;     // move one entry during insert or remove
    logic write;     // write the new or updated entry
    logic finish;    // load the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic shift_done;
  } sts_t;

endpackage

>>> rtl/ffa_ctrl.sv
module ffa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ffa_pkg::sts_t sts_i,
  output ffa_pkg::cmd_t cmd_o
);
  import ffa_pkg::*;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SScan   = 3'd1;
  localparam logic [2:0] SDecide = 3'd2;
  localparam logic [2:0] SShift  = 3'd3;
  localparam logic [2:0] SWrite  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == SIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = SScan;
        end
      end
      SScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = SDecide;
        end
      end
      SDecide: begin
        cmd_o.decide = 1'b1;
        state_d      = SShift;
      end
      SShift: begin
        if (sts_i.shift_done) begin
          state_d = SWrite;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      SWrite: begin
        cmd_o.write  = 1'b1;
        cmd_o.finish = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/ffa_dpath.sv
module ffa_dpath #(
  parameter int unsigned MaxObjects = ffa_pkg::DefaultMaxObjects
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [20:0]   cfg_data_i,
  input  ffa_pkg::req_t req_i,
  input  ffa_pkg::cmd_t cmd_i,
  output ffa_pkg::sts_t sts_o,
  output ffa_pkg::rsp_t rsp_o
);
  import ffa_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxObjects);
  localparam int unsigned CntW = $clog2(MaxObjects + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxObjects);

  entry_t mem_q [MaxObjects];
  entry_t rd_q;

  logic [20:0]     seg_q;
  logic [CntW-1:0] count_q;
  req_t            req_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic            rd_ok_q;
  logic [15:0]     low_q, high_q;
  logic [21:0]     prev_end_q;
  logic            gap_found_q;
  logic [CntW-1:0] gap_pos_q;
  logic            found_q;
  logic [CntW-1:0] found_pos_q;
  entry_t          found_e_q;
  logic [CntW-1:0] pos_q;
  logic [CntW-1:0] sh_q;
  logic            do_ins_q, do_rem_q, do_upd_q;
  logic [1:0]      st_q;
  logic [15:0]     nid_q;
  logic [19:0]     nstart_q;
  rsp_t            rsp_q;

  // Scan reads entry idx_q from memory into a register; the registered word is
  // examined in the next cycle, at index idx_q minus one.
  logic [CntW-1:0] rd_idx;
  logic [22:0]     fit_sum;
  logic [21:0]     ent_end;
  logic            is_alloc;
  logic [IdxW-1:0] mem_raddr;
  logic [CntW-1:0] sh_src;

  logic [1:0]      dec_st;
  logic            dec_ins, dec_rem, dec_upd;
  logic [CntW-1:0] dec_pos, dec_sh;
  logic [15:0]     dec_nid;

  assign is_alloc = (req_q.operation == OpAlloc);
  assign rd_idx   = idx_q - CntW'(1);
  assign ent_end  = 22'(rd_q.start) + 22'(rd_q.bytes);
  assign fit_sum  = 23'(prev_end_q) + 23'(req_q.request_bytes);
  assign sts_o.scan_done  = !rd_ok_q && (idx_q >= count_q) && (idx_q != '0 || count_q == '0)
                            ? 1'b1 : (rd_ok_q && idx_q >= count_q);
  assign sts_o.shift_done = !(do_ins_q && sh_q > pos_q) &&
                            !(do_rem_q && sh_q + CntW'(1) < count_q);

  // Insert moves entry sh-1 to sh; remove moves entry sh+1 to sh.
  assign sh_src = do_ins_q ? sh_q - CntW'(1) : sh_q + CntW'(1);

  always_comb begin
    mem_raddr = idx_q[IdxW-1:0];
    if (!cmd_i.scan) begin
      mem_raddr = sh_src[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[mem_raddr];
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.scan && idx_q < count_q) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  always_comb begin
    dec_st  = StOk;
    dec_ins = 1'b0;
    dec_rem = 1'b0;
    dec_upd = 1'b0;
    dec_pos = '0;
    dec_nid = '0;
    dec_sh  = count_q;
    if (is_alloc) begin
      if (count_q == '0) begin
        dec_ins = 1'b1;
      end else if (count_q >= MaxCnt) begin
        dec_st = StNoSpace;
      end else if (low_q == '0 && high_q == '1) begin
        dec_st = StNoSpace;
      end else begin
        dec_nid = (low_q != '0) ? low_q - 16'd1 : high_q + 16'd1;
        if (gap_found_q) begin
          dec_pos = gap_pos_q;
          dec_ins = 1'b1;
        end else if (23'(prev_end_q) + 23'(req_q.request_bytes) > 23'(seg_q) ||
                     prev_end_q > 22'(StartMax)) begin
          dec_st = StNoSpace;
        end else begin
          dec_pos = count_q;
          dec_ins = 1'b1;
        end
      end
    end else if (!found_q) begin
      dec_st = StNotFound;
    end else if (req_q.operation == OpFree) begin
      dec_rem = 1'b1;
      dec_sh  = found_pos_q;
    end else if (req_q.operation == OpAcquire && found_e_q.locked) begin
      dec_st = StBusy;
    end else begin
      dec_upd = 1'b1;
    end
  end

  // Shifting reads then writes each entry, with sh_ph_q selecting the read or write phase.
  logic sh_ph_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift && sh_ph_q) begin
      mem_q[sh_q[IdxW-1:0]] <= rd_q;
    end else if (cmd_i.write && (do_ins_q || do_upd_q)) begin
      if (do_ins_q) begin
        mem_q[pos_q[IdxW-1:0]] <= '{start: nstart_q, bytes: req_q.request_bytes,
                                     ident: nid_q, attr: req_q.attribute, locked: 1'b0};
      end else begin
        mem_q[found_pos_q[IdxW-1:0]] <= '{start: found_e_q.start, bytes: found_e_q.bytes,
                                           ident: found_e_q.ident, attr: found_e_q.attr,
                                           locked: (req_q.operation == OpAcquire)};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= SegResetBytes;
      count_q <= '0;
      sh_ph_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seg_q <= cfg_data_i;
      end
      if (cmd_i.shift) begin
        sh_ph_q <= !sh_ph_q;
      end else begin
        sh_ph_q <= 1'b0;
      end
      if (cmd_i.write) begin
        if (do_ins_q) begin
          count_q <= count_q + CntW'(1);
        end else if (do_rem_q) begin
          count_q <= count_q - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q       <= req_i;
      idx_q       <= '0;
      rd_ok_q     <= 1'b0;
      low_q       <= '1;
      high_q      <= '0;
      gap_found_q <= 1'b0;
      found_q     <= 1'b0;
    end
    if (cmd_i.scan) begin
      idx_q   <= idx_d;
      rd_ok_q <= (idx_q < count_q);
      if (rd_ok_q) begin
        if (rd_q.ident < low_q) low_q <= rd_q.ident;
        if (rd_q.ident > high_q) high_q <= rd_q.ident;
        if (!found_q && rd_q.ident == req_q.object_id) begin
          found_q     <= 1'b1;
          found_pos_q <= rd_idx;
          found_e_q   <= rd_q;
        end
        if (rd_idx != '0 && !gap_found_q && fit_sum <= 23'(rd_q.start)) begin
          gap_found_q <= 1'b1;
          gap_pos_q   <= rd_idx;
        end
        prev_end_q <= ent_end;
        if (!(rd_idx != '0 && !gap_found_q && fit_sum <= 23'(rd_q.start)) && !gap_found_q) begin
          nstart_q <= ent_end[19:0];
        end
      end
    end
    if (cmd_i.decide) begin
      do_ins_q <= dec_ins;
      do_rem_q <= dec_rem;
      do_upd_q <= dec_upd;
      st_q     <= dec_st;
      pos_q    <= dec_pos;
      nid_q    <= dec_nid;
      sh_q     <= dec_sh;
      if (is_alloc && count_q == '0) begin
        nstart_q <= '0;
      end
    end
    if (cmd_i.shift && sh_ph_q) begin
      sh_q <= do_ins_q ? sh_q - CntW'(1) : sh_q + CntW'(1);
    end
    if (cmd_i.finish) begin
      rsp_q.status <= st_q;
      if (st_q == StOk && do_ins_q) begin
        rsp_q.result_id        <= nid_q;
        rsp_q.start_offset     <= nstart_q;
        rsp_q.object_bytes     <= req_q.request_bytes;
        rsp_q.object_attribute <= req_q.attribute;
      end else if (st_q == StOk && req_q.operation == OpAcquire) begin
        rsp_q.result_id        <= '0;
        rsp_q.start_offset     <= found_e_q.start;
        rsp_q.object_bytes     <= found_e_q.bytes;
        rsp_q.object_attribute <= found_e_q.attr;
      end else begin
        rsp_q.result_id        <= '0;
        rsp_q.start_offset     <= '0;
        rsp_q.object_bytes     <= '0;
        rsp_q.object_attribute <= '0;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

>>> rtl/first_fit_object_allocator.sv
// First-fit allocator for up to MAX_OBJECTS objects in one segment, kept in a
// table ordered by start offset. Each item scans the table one entry a cycle
// through the memory read port, then inserts or removes an entry by moving the
// entries behind it one at a time, each read and then written, or updates the
// lock of a found entry. A new item is taken once the previous result has been
// collected. segment_bytes is written through cfg_we_i and cfg_data_i; the user
// must write it only while the block is idle, which the block does not enforce.
module first_fit_object_allocator #(
  parameter int unsigned MAX_OBJECTS = ffa_pkg::DefaultMaxObjects
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [20:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ffa_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ffa_pkg::rsp_t out_data_o
);
  import ffa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffa_dpath #(
    .MaxObjects (MAX_OBJECTS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (out_data_o)
  );

endmodule
